// File: rtl/swc_pkg.sv
// types, register codes and duty patterns shared by the square wave channel
`timescale 1ns / 1ps

package swc_pkg;

	typedef enum logic [1:0] {
		ACT_TICK  = 2'd0,
		ACT_READ  = 2'd1,
		ACT_WRITE = 2'd2
	} action_t;

	localparam logic [2:0] REG_DUTY    = 3'd1;
	localparam logic [2:0] REG_FREQ_LO = 3'd3;
	localparam logic [2:0] REG_FREQ_HI = 3'd4;

	localparam logic [7:0] RD_MASK_DUTY  = 8'h3F;
	localparam logic [7:0] RD_MASK_FREQ  = 8'hFF;
	localparam logic [7:0] RD_MASK_CTRL  = 8'hBF;
	localparam logic [3:0] FULL_VOLUME   = 4'd15;
	localparam logic [11:0] FREQ_BASE    = 12'd2048;

	localparam int unsigned IN_TDATA_W  = 16;
	localparam int unsigned OUT_TDATA_W = 16;

	typedef struct packed {
		logic [1:0] action;
		logic [2:0] reg_index;
		logic [7:0] write_data;
	} item_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic [3:0] sample;
	} result_t;

	function automatic logic [7:0] duty_pattern(input logic [1:0] sel);
		logic [7:0] pat;
		case (sel)
			2'd0:    pat = 8'b0000_0001;
			2'd1:    pat = 8'b1000_0001;
			2'd2:    pat = 8'b1000_0111;
			default: pat = 8'b0111_1110;
		endcase
		return pat;
	endfunction

endpackage

// File: rtl/swc_core.sv
// channel state registers and per-word update logic
`timescale 1ns / 1ps

module swc_core import swc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    en,
	input  item_t   item,
	output result_t result
);

	logic [1:0]  duty_select_q;
	logic [2:0]  duty_position_q;
	logic [7:0]  freq_low_bits_q;
	logic [2:0]  freq_high_bits_q;
	logic [15:0] period_timer_q;
	logic        output_bit_q;
	logic        channel_on_q;
	logic        length_enable_q;

	logic [1:0]  duty_select_d;
	logic [2:0]  duty_position_d;
	logic [7:0]  freq_low_bits_d;
	logic [2:0]  freq_high_bits_d;
	logic [15:0] period_timer_d;
	logic        output_bit_d;
	logic        channel_on_d;
	logic        length_enable_d;

	logic [15:0] timer_dec;
	logic [15:0] reload_cur;
	logic [15:0] reload_new;
	logic [11:0] span_cur;
	logic [11:0] span_new;
	logic [7:0]  pattern;
	logic [7:0]  rd;

	assign span_cur   = FREQ_BASE - {1'b0, freq_high_bits_q, freq_low_bits_q};
	assign span_new   = FREQ_BASE - {1'b0, item.write_data[2:0], freq_low_bits_q};
	assign reload_cur = {2'b00, span_cur, 2'b00};
	assign reload_new = {2'b00, span_new, 2'b00};
	assign timer_dec  = period_timer_q - 16'd1;
	assign pattern    = duty_pattern(duty_select_q);

	always_comb begin
		duty_select_d    = duty_select_q;
		duty_position_d  = duty_position_q;
		freq_low_bits_d  = freq_low_bits_q;
		freq_high_bits_d = freq_high_bits_q;
		period_timer_d   = period_timer_q;
		output_bit_d     = output_bit_q;
		channel_on_d     = channel_on_q;
		length_enable_d  = length_enable_q;
		rd               = 8'h00;
		case (item.action)
			ACT_TICK: begin
				period_timer_d = timer_dec;
				if (timer_dec == 16'd0) begin
					period_timer_d  = reload_cur;
					output_bit_d    = pattern[duty_position_q];
					duty_position_d = duty_position_q + 3'd1;
				end
			end
			ACT_READ: begin
				case (item.reg_index)
					REG_DUTY:    rd = {duty_select_q, RD_MASK_DUTY[5:0]};
					REG_FREQ_LO: rd = RD_MASK_FREQ;
					REG_FREQ_HI: rd = RD_MASK_CTRL | {1'b0, length_enable_q, 6'b0};
					default:     rd = 8'h00;
				endcase
			end
			ACT_WRITE: begin
				case (item.reg_index)
					REG_DUTY:    duty_select_d = item.write_data[7:6];
					REG_FREQ_LO: freq_low_bits_d = item.write_data;
					REG_FREQ_HI: begin
						length_enable_d  = item.write_data[6];
						freq_high_bits_d = item.write_data[2:0];
						if (item.write_data[7]) begin
							channel_on_d   = 1'b1;
							period_timer_d = reload_new;
						end
					end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	assign result.read_data = rd;
	assign result.sample    = (channel_on_d && output_bit_d) ? FULL_VOLUME : 4'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duty_select_q    <= '0;
			duty_position_q  <= '0;
			freq_low_bits_q  <= '0;
			freq_high_bits_q <= '0;
			period_timer_q   <= '0;
			output_bit_q     <= 1'b0;
			channel_on_q     <= 1'b0;
			length_enable_q  <= 1'b0;
		end else if (en) begin
			duty_select_q    <= duty_select_d;
			duty_position_q  <= duty_position_d;
			freq_low_bits_q  <= freq_low_bits_d;
			freq_high_bits_q <= freq_high_bits_d;
			period_timer_q   <= period_timer_d;
			output_bit_q     <= output_bit_d;
			channel_on_q     <= channel_on_d;
			length_enable_q  <= length_enable_d;
		end
	end

endmodule

// File: rtl/square_wave_channel.sv
// top level: input word register, channel core and result register
// two register stages; the result is registered as its word leaves stage one
// throughput: one word per cycle unless the result side stalls the core
// both registers advance together while the result side is free or being taken
// reset: all channel state cleared, both register stages empty
`timescale 1ns / 1ps

module square_wave_channel import swc_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // reg_index[2:0], write_data[10:3]
	input  logic [1:0]             s_axis_tuser,  // action[1:0]
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata   // read_data[7:0], sample[11:8]
);

	item_t   item_s1;
	logic    valid_s1;
	result_t result_s2;
	logic    valid_s2;
	result_t core_result;
	logic    advance;

	assign advance       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			item_s1.action     <= s_axis_tuser;
			item_s1.reg_index  <= s_axis_tdata[2:0];
			item_s1.write_data <= s_axis_tdata[10:3];
		end
	end

	swc_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (advance),
		.item   (item_s1),
		.result (core_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || m_axis_tready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= core_result;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {4'h0, result_s2.sample, result_s2.read_data};

endmodule

// File: bench/testbench.sv
// testbench for square_wave_channel: shadow channel state, register traffic and tone runs
`timescale 1ns / 1ps

module testbench;
	import swc_pkg::*;

	localparam logic [1:0] ACT_SPARE      = 2'd3;
	localparam logic [2:0] REG_OUT_RANGE  = 3'd5;
	localparam logic [7:0] TRIGGER_BIT    = 8'h80;
	localparam logic [7:0] LENGTH_BIT     = 8'h40;
	localparam int         DIRECTED_WORDS = 28;
	localparam int         RANDOM_WORDS   = 1250;

	class square_channel_shadow;
		logic [3:0][7:0] wave_table;
		logic [1:0]      duty_sel;
		logic [2:0]      wave_pos;
		logic [7:0]      freq_lo;
		logic [2:0]      freq_hi;
		logic [15:0]     period_count;
		logic            level_bit;
		logic            running;
		logic            length_en;
		result_t         awaited[$];
		int              errors;

		function new();
			wave_table = {8'h7E, 8'h87, 8'h81, 8'h01};
			duty_sel = '0;
			wave_pos = '0;
			freq_lo = '0;
			freq_hi = '0;
			period_count = '0;
			level_bit = 1'b0;
			running = 1'b0;
			length_en = 1'b0;
			errors = 0;
		endfunction

		function logic [15:0] period_reload();
			logic [15:0] f;
			f = {5'b0, freq_hi, freq_lo};
			return (16'(FREQ_BASE) - f) << 2;
		endfunction

		function void apply_word(logic [1:0] act, logic [2:0] idx, logic [7:0] dat);
			result_t r;
			r.read_data = '0;
			case (act)
				ACT_TICK: begin
					period_count = period_count - 16'd1;
					if (period_count == '0) begin
						period_count = period_reload();
						level_bit = wave_table[duty_sel][wave_pos];
						wave_pos = wave_pos + 3'd1;
					end
				end
				ACT_READ: begin
					case (idx)
						REG_DUTY:    r.read_data = {duty_sel, 6'b0} | RD_MASK_DUTY;
						REG_FREQ_LO: r.read_data = RD_MASK_FREQ;
						REG_FREQ_HI: r.read_data = RD_MASK_CTRL | (length_en ? LENGTH_BIT : 8'h00);
						default:     r.read_data = '0;
					endcase
				end
				ACT_WRITE: begin
					case (idx)
						REG_DUTY:    duty_sel = dat[7:6];
						REG_FREQ_LO: freq_lo = dat;
						REG_FREQ_HI: begin
							length_en = dat[6];
							freq_hi = dat[2:0];
							if ((dat & TRIGGER_BIT) != '0) begin
								running = 1'b1;
								period_count = period_reload();
							end
						end
						default: ;
					endcase
				end
				default: ;
			endcase
			r.sample = (running && level_bit) ? FULL_VOLUME : 4'd0;
			awaited.push_back(r);
		endfunction

		task report(string msg);
			if (errors < 40)
				$display("mismatch: %s", msg);
			errors++;
		endtask

		task check_output(logic [7:0] rd, logic [3:0] smp);
			result_t want;
			if (awaited.size() == 0) begin
				report($sformatf("unexpected word read_data=%02h sample=%0d", rd, smp));
			end else begin
				want = awaited.pop_front();
				if (rd !== want.read_data)
					report($sformatf("read_data %02h, expected %02h", rd, want.read_data));
				if (smp !== want.sample)
					report($sformatf("sample %0d, expected %0d", smp, want.sample));
			end
		endtask
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;   // reg_index[2:0], write_data[10:3]
	logic [1:0]             s_axis_tuser = '0;   // action[1:0]
	logic                   m_axis_tready = 1'b0;
	wire                    s_axis_tready;
	wire                    m_axis_tvalid;
	wire [OUT_TDATA_W-1:0]  m_axis_tdata;        // read_data[7:0], sample[11:8]

	square_channel_shadow shadow;
	logic                 quiet_phase = 1'b0;
	int                   sent = 0;

	square_wave_channel u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic int idle_span();
		int r;
		r = $urandom_range(0, 99);
		if (quiet_phase || r < 75)
			return 0;
		if (r < 96)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic send_word(input logic [1:0] act, input logic [2:0] idx, input logic [7:0] dat);
		int gap;
		gap = idle_span();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {5'b0, dat, idx};
		s_axis_tuser <= act;
		do @(posedge clk); while (!s_axis_tready);
		shadow.apply_word(act, idx, dat);
		sent++;
	endtask

	task automatic drain_pause();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (shadow.awaited.size() != 0);
	endtask

	task automatic tone_burst();
		int ticks;
		logic [7:0] lo;
		logic [2:0] hi;
		lo = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(8'hE0, 8'hFF)) : 8'($urandom());
		hi = ($urandom_range(0, 4) != 0) ? 3'd7 : 3'($urandom());
		if ($urandom_range(0, 1) != 0)
			send_word(ACT_WRITE, REG_DUTY, 8'($urandom()));
		send_word(ACT_WRITE, REG_FREQ_LO, lo);
		send_word(ACT_WRITE, REG_FREQ_HI,
			{($urandom_range(0, 7) != 0), 1'($urandom()), 3'($urandom()), hi});
		ticks = $urandom_range(4, 60);
		repeat (ticks) begin
			case ($urandom_range(0, 19))
				0, 1:    send_word(ACT_READ, 3'($urandom()), 8'($urandom()));
				2:       send_word(ACT_WRITE, REG_DUTY, 8'($urandom()));
				default: send_word(ACT_TICK, 3'($urandom()), 8'($urandom()));
			endcase
		end
	endtask

	initial begin : drain_side
		int hold;
		hold = 0;
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready)
				shadow.check_output(m_axis_tdata[7:0], m_axis_tdata[11:8]);
			if (hold == 0)
				hold = idle_span();
			if (hold > 0) begin
				m_axis_tready <= 1'b0;
				hold--;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	initial begin : stimulus
		shadow = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// first tick before any trigger wraps the timer
		send_word(ACT_TICK, '0, '0);
		for (int i = 0; i < 8; i++)
			send_word(ACT_READ, 3'(i), 8'hFF);
		send_word(ACT_SPARE, REG_FREQ_HI, 8'hFF);
		send_word(ACT_WRITE, REG_DUTY, 8'hC0);
		send_word(ACT_READ, REG_DUTY, 8'h00);
		send_word(ACT_WRITE, REG_FREQ_LO, 8'hFF);
		// trigger reload must use the high bits written in the same word
		send_word(ACT_WRITE, REG_FREQ_HI, TRIGGER_BIT | LENGTH_BIT | 8'h07);
		send_word(ACT_READ, REG_FREQ_HI, 8'h00);
		repeat (8) send_word(ACT_TICK, '1, 8'hFF);
		send_word(ACT_WRITE, REG_OUT_RANGE, 8'hFF);
		send_word(ACT_READ, REG_OUT_RANGE, 8'h00);
		send_word(ACT_WRITE, REG_FREQ_LO, 8'h00);
		send_word(ACT_WRITE, REG_FREQ_HI, TRIGGER_BIT);
		send_word(ACT_TICK, '0, '0);

		drain_pause();
		while (sent < DIRECTED_WORDS + RANDOM_WORDS) begin
			if ($urandom_range(0, 9) == 0)
				quiet_phase = !quiet_phase;
			if ($urandom_range(0, 24) == 0)
				drain_pause();
			if ($urandom_range(0, 99) < 70)
				tone_burst();
			else
				send_word(2'($urandom()), 3'($urandom()), 8'($urandom()));
		end
		s_axis_tvalid <= 1'b0;

		while (shadow.awaited.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (shadow.errors == 0 && shadow.awaited.size() == 0)
			$display("square_wave_channel test passed");
		else
			$display("square_wave_channel test failed");
		$finish;
	end

	initial begin : watchdog
		#12_000_000;
		$display("square_wave_channel test failed");
		$finish;
	end

endmodule

// File: filelist.f
rtl/swc_pkg.sv
rtl/swc_core.sv
rtl/square_wave_channel.sv
bench/testbench.sv
